// File: rtl/segment_point_nearest_in_disk_unit_macros.svh
// Assertion macros for the segment point nearest in disk unit.
// Used by the checker file; expects signals named clk and rst in scope.
`ifndef SEGMENT_POINT_NEAREST_IN_DISK_UNIT_MACROS_SVH
`define SEGMENT_POINT_NEAREST_IN_DISK_UNIT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define SPND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, including reset cycles.
`define SPND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/spnd_pkg.sv
// Shared constants for the segment point nearest in disk unit.
// No dependencies; used by the top level and the checker.
`default_nettype none

package spnd_pkg;

  // Result case codes.
  localparam logic [2:0] CASE_CENTER    = 3'd0;
  localparam logic [2:0] CASE_END_IN    = 3'd1;
  localparam logic [2:0] CASE_END_PULL  = 3'd2;
  localparam logic [2:0] CASE_PROJ_IN   = 3'd3;
  localparam logic [2:0] CASE_PROJ_PULL = 3'd4;

endpackage

`default_nettype wire

// File: rtl/spnd_delay.sv
// Delay line that carries a valid bit and a context word alongside a unit.
// No dependencies.
`default_nettype none

module spnd_delay #(
  parameter int DW  = 8,
  parameter int LEN = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  output logic [DW-1:0] out_data
);

  logic [LEN-1:0] vld;
  logic [DW-1:0]  dat [LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < LEN; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dat[0] <= in_data;
    for (int i = 1; i < LEN; i++) begin
      dat[i] <= dat[i-1];
    end
  end

  assign out_valid = vld[LEN-1];
  assign out_data  = dat[LEN-1];

endmodule

`default_nettype wire

// File: rtl/spnd_muldiv.sv
// Pipelined floor or rounded a*m/den for a < den, one bit of m per stage.
// No dependencies.
`default_nettype none

module spnd_muldiv #(
  parameter int AW    = 66,
  parameter int MW    = 33,
  parameter int ROUND = 1
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [MW-1:0] mul,
  input  logic [AW-1:0] den,
  output logic [MW-1:0] q
);

  logic [AW-1:0] rem_s [MW+1];
  logic [AW-1:0] den_s [MW+1];
  logic [AW-1:0] a_s   [MW];
  logic [MW-1:0] m_s   [MW];
  logic [MW-1:0] q_s   [MW+1];

  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign den_s[0] = den;
  assign a_s[0]   = a;
  assign m_s[0]   = mul;

  for (genvar k = 0; k < MW; k++) begin : g_step
    logic [AW+1:0] t;
    logic [AW+1:0] lo_cmp;
    logic [AW+1:0] hi_cmp;
    logic [AW+1:0] rn;
    logic [1:0]    dig;

    // The partial remainder stays below den, so the new digit is 0, 1 or 2.
    always_comb begin
      t      = {1'b0, rem_s[k], 1'b0} + (m_s[k][MW-1-k] ? {2'b00, a_s[k]} : '0);
      lo_cmp = {2'b00, den_s[k]};
      hi_cmp = {1'b0, den_s[k], 1'b0};
      if (t >= hi_cmp) begin
        dig = 2'd2;
        rn  = t - hi_cmp;
      end else if (t >= lo_cmp) begin
        dig = 2'd1;
        rn  = t - lo_cmp;
      end else begin
        dig = 2'd0;
        rn  = t;
      end
    end

    always_ff @(posedge clk) begin
      rem_s[k+1] <= rn[AW-1:0];
      q_s[k+1]   <= {q_s[k][MW-2:0], 1'b0} + MW'(dig);
      den_s[k+1] <= den_s[k];
    end

    if (k < MW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        a_s[k+1] <= a_s[k];
        m_s[k+1] <= m_s[k];
      end
    end
  end

  logic [AW:0] rem2;
  logic        up;

  always_comb begin
    rem2 = {rem_s[MW], 1'b0};
    up   = (ROUND != 0) && (rem2 >= {1'b0, den_s[MW]});
  end

  always_ff @(posedge clk) begin
    q <= q_s[MW] + MW'(up);
  end

endmodule

`default_nettype wire

// File: rtl/spnd_isqrt.sv
// Pipelined ceiling square root, one root bit per stage.
// No dependencies.
`default_nettype none

module spnd_isqrt #(
  parameter int K = 33
) (
  input  logic           clk,
  input  logic [2*K-1:0] n,
  output logic [K:0]     s
);

  logic [K+1:0]   rem_s  [K+1];
  logic [K-1:0]   root_s [K+1];
  logic [2*K-1:0] n_s    [K];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign n_s[0]    = n;

  for (genvar j = 0; j < K; j++) begin : g_step
    logic [K+3:0] rt;
    logic [K+3:0] trial;
    logic [K+3:0] rn;
    logic         hit;

    always_comb begin
      rt    = {rem_s[j], n_s[j][2*K-1-2*j -: 2]};
      trial = {2'b00, root_s[j], 2'b01};
      hit   = (rt >= trial);
      rn    = hit ? (rt - trial) : rt;
    end

    always_ff @(posedge clk) begin
      rem_s[j+1]  <= rn[K+1:0];
      root_s[j+1] <= {root_s[j][K-2:0], hit};
    end

    if (j < K - 1) begin : g_pass
      always_ff @(posedge clk) begin
        n_s[j+1] <= n_s[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    s <= {1'b0, root_s[K]} + (K+1)'(rem_s[K] != '0);
  end

endmodule

`default_nettype wire

// File: rtl/segment_point_nearest_in_disk_unit.sv
// Segment point nearest in disk: for a disk (center, radius) and a segment
// (first, second), all signed fixed point, returns the segment point closest
// to the center, pulled onto or just inside the disk boundary when it lies
// outside. A zero radius returns the center; equal endpoints use the first.
//
// Requests: a request is accepted at a rising edge with start high and busy
// low. busy is always low: the pipeline takes a new request every cycle.
// Results: done is high for exactly one cycle with result_x, result_y and
// case_code; the receiver cannot hold results off and none is needed.
//
// The projection divider, the square root and the boundary divider each
// resolve one bit per pipeline stage. Throughput is one request per cycle.
//
// Reset clears all valid bits, so done stays low until a request made after
// reset reaches the end. No clearing pass is needed.
`default_nettype none

module segment_point_nearest_in_disk_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic        [COORD_WIDTH-2:0] radius,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] result_x,
  output logic signed [COORD_WIDTH-1:0] result_y,
  output logic        [2:0]             case_code
);

  localparam int W     = COORD_WIDTH;
  localparam int EW    = W + 1;       // differences and their magnitudes
  localparam int PW    = 2 * W + 2;   // products and sums of squares
  localparam int SK    = W + 1;       // square root bits
  localparam int SW    = SK + 1;      // ceiling root width
  localparam int LAT_A = EW + 1;
  localparam int LAT_S = SK + 1;
  localparam int LAT_B = EW + 1;

  typedef enum logic [1:0] {SEL_FIRST, SEL_SECOND, SEL_INNER} sel_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic [W-2:0]        r;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic signed [W-1:0] x2;
    logic signed [W-1:0] y2;
  } geo_t;

  typedef struct packed {
    sel_t  sel;
    logic  proj;
    logic  ndx;
    logic  ndy;
    geo_t  geo;
  } ctx_a_t;

  typedef struct packed {
    logic                in_disk;
    logic                proj;
    logic                nex;
    logic                ney;
    logic [EW-1:0]       aex;
    logic [EW-1:0]       aey;
    logic signed [W-1:0] qx;
    logic signed [W-1:0] qy;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic [W-2:0]        r;
  } ctx_s_t;

  function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
    return v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

  // The pipeline never stalls, so a request is taken whenever start is high.
  assign busy = 1'b0;

  // Stage 1: input registers.
  logic v1;
  geo_t s1_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_geo <= '{cx: center_x, cy: center_y, r: radius,
                x1: first_x, y1: first_y, x2: second_x, y2: second_y};
  end

  // Stage 2: segment direction d and center offset a, as sign and magnitude.
  logic signed [EW-1:0] dx_c, dy_c, ax_c, ay_c;
  logic                 v2;
  geo_t                 s2_geo;
  logic [EW-1:0]        s2_adx, s2_ady, s2_aax, s2_aay;
  logic                 s2_ndx, s2_ndy, s2_na, s2_nb;

  always_comb begin
    dx_c = EW'(s1_geo.x2) - EW'(s1_geo.x1);
    dy_c = EW'(s1_geo.y2) - EW'(s1_geo.y1);
    ax_c = EW'(s1_geo.cx) - EW'(s1_geo.x1);
    ay_c = EW'(s1_geo.cy) - EW'(s1_geo.y1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    s2_geo <= s1_geo;
    s2_adx <= mag(dx_c);
    s2_ady <= mag(dy_c);
    s2_aax <= mag(ax_c);
    s2_aay <= mag(ay_c);
    s2_ndx <= dx_c[EW-1];
    s2_ndy <= dy_c[EW-1];
    s2_na  <= ax_c[EW-1] ^ dx_c[EW-1];
    s2_nb  <= ay_c[EW-1] ^ dy_c[EW-1];
  end

  // Stage 3: the four products of the dot products a.d and d.d.
  logic          v3;
  geo_t          s3_geo;
  logic [PW-1:0] s3_pa, s3_pb, s3_dxx, s3_dyy;
  logic [EW-1:0] s3_adx, s3_ady;
  logic          s3_ndx, s3_ndy, s3_na, s3_nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s3_geo <= s2_geo;
    s3_pa  <= s2_aax * s2_adx;
    s3_pb  <= s2_aay * s2_ady;
    s3_dxx <= s2_adx * s2_adx;
    s3_dyy <= s2_ady * s2_ady;
    s3_adx <= s2_adx;
    s3_ady <= s2_ady;
    s3_ndx <= s2_ndx;
    s3_ndy <= s2_ndy;
    s3_na  <= s2_na;
    s3_nb  <= s2_nb;
  end

  // Stage 4: signed sum a.d as sign and magnitude, and d.d.
  logic [PW-1:0] num_c;
  logic          neg_c;
  logic          v4;
  geo_t          s4_geo;
  logic [PW-1:0] s4_num, s4_den;
  logic          s4_neg;
  logic [EW-1:0] s4_adx, s4_ady;
  logic          s4_ndx, s4_ndy;

  always_comb begin
    if (s3_na == s3_nb) begin
      num_c = s3_pa + s3_pb;
      neg_c = s3_na;
    end else if (s3_pa >= s3_pb) begin
      num_c = s3_pa - s3_pb;
      neg_c = s3_na;
    end else begin
      num_c = s3_pb - s3_pa;
      neg_c = s3_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s4_geo <= s3_geo;
    s4_num <= num_c;
    s4_neg <= neg_c;
    s4_den <= s3_dxx + s3_dyy;
    s4_adx <= s3_adx;
    s4_ady <= s3_ady;
    s4_ndx <= s3_ndx;
    s4_ndy <= s3_ndy;
  end

  // Stage 5: choose the first end, the second end or the interior point.
  // The divider only sees a nonzero dividend for an interior projection.
  logic          deg_c;
  sel_t          sel_c;
  logic          v5;
  ctx_a_t        s5_ctx;
  logic [PW-1:0] s5_num, s5_den;
  logic [EW-1:0] s5_adx, s5_ady;

  always_comb begin
    deg_c = (s4_den == '0);
    if (deg_c || s4_neg || s4_num == '0) begin
      sel_c = SEL_FIRST;
    end else if (s4_num >= s4_den) begin
      sel_c = SEL_SECOND;
    end else begin
      sel_c = SEL_INNER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s5_ctx <= '{sel: sel_c, proj: !deg_c, ndx: s4_ndx, ndy: s4_ndy, geo: s4_geo};
    s5_num <= (sel_c == SEL_INNER) ? s4_num : '0;
    s5_den <= s4_den;
    s5_adx <= s4_adx;
    s5_ady <= s4_ady;
  end

  // Projection offsets round(num * |d| / den), one quotient bit per stage.
  logic [EW-1:0] ox, oy;
  logic          va;
  ctx_a_t        ctx_a;

  spnd_muldiv #(.AW(PW), .MW(EW), .ROUND(1)) u_div_px (
    .clk (clk),
    .a   (s5_num),
    .mul (s5_adx),
    .den (s5_den),
    .q   (ox)
  );

  spnd_muldiv #(.AW(PW), .MW(EW), .ROUND(1)) u_div_py (
    .clk (clk),
    .a   (s5_num),
    .mul (s5_ady),
    .den (s5_den),
    .q   (oy)
  );

  spnd_delay #(.DW($bits(ctx_a_t)), .LEN(LAT_A)) u_dly_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_data   (s5_ctx),
    .out_valid (va),
    .out_data  (ctx_a)
  );

  // Stage 6: the clamped projection q.
  logic signed [EW:0]  px_c, py_c;
  logic signed [W-1:0] qx_c, qy_c;
  logic                v6;
  logic signed [W-1:0] s6_qx, s6_qy, s6_cx, s6_cy;
  logic [W-2:0]        s6_r;
  logic                s6_proj;

  always_comb begin
    px_c = (EW+1)'(ctx_a.geo.x1) + (ctx_a.ndx ? -$signed({1'b0, ox}) : $signed({1'b0, ox}));
    py_c = (EW+1)'(ctx_a.geo.y1) + (ctx_a.ndy ? -$signed({1'b0, oy}) : $signed({1'b0, oy}));
    case (ctx_a.sel)
      SEL_FIRST: begin
        qx_c = ctx_a.geo.x1;
        qy_c = ctx_a.geo.y1;
      end
      SEL_SECOND: begin
        qx_c = ctx_a.geo.x2;
        qy_c = ctx_a.geo.y2;
      end
      default: begin
        qx_c = px_c[W-1:0];
        qy_c = py_c[W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= va;
    end
  end

  always_ff @(posedge clk) begin
    s6_qx   <= qx_c;
    s6_qy   <= qy_c;
    s6_cx   <= ctx_a.geo.cx;
    s6_cy   <= ctx_a.geo.cy;
    s6_r    <= ctx_a.geo.r;
    s6_proj <= ctx_a.proj;
  end

  // Stage 7: offset e = q - center as sign and magnitude.
  logic signed [EW-1:0] ex_c, ey_c;
  logic                 v7;
  logic [EW-1:0]        s7_aex, s7_aey;
  logic                 s7_nex, s7_ney;
  logic signed [W-1:0]  s7_qx, s7_qy, s7_cx, s7_cy;
  logic [W-2:0]         s7_r;
  logic                 s7_proj;

  always_comb begin
    ex_c = EW'(s6_qx) - EW'(s6_cx);
    ey_c = EW'(s6_qy) - EW'(s6_cy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    s7_aex  <= mag(ex_c);
    s7_aey  <= mag(ey_c);
    s7_nex  <= ex_c[EW-1];
    s7_ney  <= ey_c[EW-1];
    s7_qx   <= s6_qx;
    s7_qy   <= s6_qy;
    s7_cx   <= s6_cx;
    s7_cy   <= s6_cy;
    s7_r    <= s6_r;
    s7_proj <= s6_proj;
  end

  // Stage 8: squares of e and of the radius.
  logic [2*W-3:0] rr_c;
  logic           v8;
  logic [PW-1:0]  s8_exx, s8_eyy, s8_rr;
  ctx_s_t         s8_ctx;

  assign rr_c = s7_r * s7_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    s8_exx <= s7_aex * s7_aex;
    s8_eyy <= s7_aey * s7_aey;
    s8_rr  <= PW'(rr_c);
    s8_ctx <= '{in_disk: 1'b0, proj: s7_proj, nex: s7_nex, ney: s7_ney,
                aex: s7_aex, aey: s7_aey, qx: s7_qx, qy: s7_qy,
                cx: s7_cx, cy: s7_cy, r: s7_r};
  end

  // Stage 9: squared distance e.e.
  logic          v9;
  logic [PW-1:0] s9_d2, s9_rr;
  ctx_s_t        s9_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    s9_d2  <= s8_exx + s8_eyy;
    s9_rr  <= s8_rr;
    s9_ctx <= s8_ctx;
  end

  // Stage 10: inside test against the squared radius.
  ctx_s_t        s9_ctx_c;
  logic          v10;
  logic [PW-1:0] s10_d2;
  ctx_s_t        s10_ctx;

  always_comb begin
    s9_ctx_c         = s9_ctx;
    s9_ctx_c.in_disk = (s9_d2 <= s9_rr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    s10_d2  <= s9_d2;
    s10_ctx <= s9_ctx_c;
  end

  // Ceiling of |e|, one root bit per stage.
  logic [SW-1:0] root_up;
  logic          vs;
  ctx_s_t        ctx_s;

  spnd_isqrt #(.K(SK)) u_sqrt (
    .clk (clk),
    .n   (s10_d2),
    .s   (root_up)
  );

  spnd_delay #(.DW($bits(ctx_s_t)), .LEN(LAT_S)) u_dly_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10),
    .in_data   (s10_ctx),
    .out_valid (vs),
    .out_data  (ctx_s)
  );

  // Boundary offsets floor(r * |e| / ceil(|e|)); r stays below the root
  // whenever the point is outside, so the results stay inside the disk.
  logic [SW-1:0] r_ext;
  logic [EW-1:0] bx, by;
  logic          vb;
  ctx_s_t        ctx_b;

  assign r_ext = SW'(ctx_s.r);

  spnd_muldiv #(.AW(SW), .MW(EW), .ROUND(0)) u_div_bx (
    .clk (clk),
    .a   (r_ext),
    .mul (ctx_s.aex),
    .den (root_up),
    .q   (bx)
  );

  spnd_muldiv #(.AW(SW), .MW(EW), .ROUND(0)) u_div_by (
    .clk (clk),
    .a   (r_ext),
    .mul (ctx_s.aey),
    .den (root_up),
    .q   (by)
  );

  spnd_delay #(.DW($bits(ctx_s_t)), .LEN(LAT_B)) u_dly_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .in_data   (ctx_s),
    .out_valid (vb),
    .out_data  (ctx_b)
  );

  // Final stage: pick center, inside point or pulled point.
  logic signed [EW:0] rx_c, ry_c;

  always_comb begin
    rx_c = (EW+1)'(ctx_b.cx) + (ctx_b.nex ? -$signed({1'b0, bx}) : $signed({1'b0, bx}));
    ry_c = (EW+1)'(ctx_b.cy) + (ctx_b.ney ? -$signed({1'b0, by}) : $signed({1'b0, by}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctx_b.r == '0) begin
      result_x  <= ctx_b.cx;
      result_y  <= ctx_b.cy;
      case_code <= spnd_pkg::CASE_CENTER;
    end else if (ctx_b.in_disk) begin
      result_x  <= ctx_b.qx;
      result_y  <= ctx_b.qy;
      case_code <= ctx_b.proj ? spnd_pkg::CASE_PROJ_IN : spnd_pkg::CASE_END_IN;
    end else begin
      result_x  <= rx_c[W-1:0];
      result_y  <= ry_c[W-1:0];
      case_code <= ctx_b.proj ? spnd_pkg::CASE_PROJ_PULL : spnd_pkg::CASE_END_PULL;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spnd_checker.sv
// Port-level checks for the segment point nearest in disk unit, with bind.
// Depends on spnd_pkg and the assertion macro header.
`default_nettype none
`include "segment_point_nearest_in_disk_unit_macros.svh"

module spnd_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [COORD_WIDTH-1:0] center_x,
  input logic [COORD_WIDTH-2:0] radius,
  input logic                   done,
  input logic [COORD_WIDTH-1:0] result_x,
  input logic [2:0]             case_code
);

  localparam int LATENCY = 11 + 3 * (COORD_WIDTH + 2);

  `SPND_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !done, "done high right after reset")
  `SPND_ASSERT(a_no_busy, !busy, "busy raised although the pipeline never stalls")
  `SPND_ASSERT(a_request_done, start |-> ##LATENCY done, "request gave no result")
  `SPND_ASSERT(a_no_spurious, !start |-> ##LATENCY !done, "result without a request")
  `SPND_ASSERT(a_zero_radius, (start && radius == '0) |-> ##LATENCY (case_code == spnd_pkg::CASE_CENTER && result_x == $past(center_x, LATENCY)), "zero radius must return the center")

endmodule

bind segment_point_nearest_in_disk_unit spnd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .center_x  (center_x),
  .radius    (radius),
  .done      (done),
  .result_x  (result_x),
  .case_code (case_code)
);

`default_nettype wire
